// File: design/imu_report_frame_encoder_core_macros.svh
// Assertion macros for the IMU report frame encoder checker.
`ifndef IMU_REPORT_FRAME_ENCODER_CORE_MACROS_SVH
`define IMU_REPORT_FRAME_ENCODER_CORE_MACROS_SVH

// Next-cycle implication, disabled while reset is asserted.
`define IRFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define IRFE_ASSERT_NEXT_NR(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/irfe_pkg.sv
// Shared constants, types and kind lookup functions for the IMU report frame encoder.
package irfe_pkg;

  localparam int VALUE_FRAC_BITS_DEF = 16;

  localparam int IN_W    = 32;
  localparam int Q_W     = 16;
  localparam int MUL_W   = 21;
  localparam int DIV_W   = 13;
  localparam int P_W     = IN_W + MUL_W;
  localparam int PLO_W   = DIV_W + Q_W - 1;
  localparam int RECIP_SHIFT = PLO_W;
  localparam int RECIP_W = 26;
  localparam int TMUL_W  = 12;
  localparam int TP_W    = IN_W + TMUL_W;
  localparam int TOFS_W  = 17;
  localparam int FRAME_LEN = 11;
  localparam int IDX_W   = 4;

  localparam logic [1:0] KIND_ACCEL = 2'd0;
  localparam logic [1:0] KIND_RATE  = 2'd1;
  localparam logic [1:0] KIND_ANGLE = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  localparam logic [7:0] SYNC_BYTE = 8'h55;
  localparam logic [7:0] ID_ACCEL  = 8'h51;
  localparam logic [7:0] ID_RATE   = 8'h52;
  localparam logic [7:0] ID_ANGLE  = 8'h53;

  // Scale factors reduced to lowest terms: accel 32767*1e5/(16*979135) = 1321250/6317
  localparam int ACCEL_MUL_I = 1321250;
  localparam int ACCEL_DIV_I = 6317;
  localparam int RATE_MUL_I  = 32767;
  localparam int RATE_DIV_I  = 2000;
  localparam int ANGLE_MUL_I = 32767;
  localparam int ANGLE_DIV_I = 180;
  // (t*34000 - 1242020*S) / (100*S) reduced by 20
  localparam int TEMP_MUL_I  = 1700;
  localparam int TEMP_OFS_I  = 62101;
  localparam int TEMP_DIV_I  = 5;

  localparam logic [RECIP_W-1:0] RECIP_ACCEL =
    RECIP_W'((longint'(1) << RECIP_SHIFT) / ACCEL_DIV_I);
  localparam logic [RECIP_W-1:0] RECIP_RATE  =
    RECIP_W'((longint'(1) << RECIP_SHIFT) / RATE_DIV_I);
  localparam logic [RECIP_W-1:0] RECIP_ANGLE =
    RECIP_W'((longint'(1) << RECIP_SHIFT) / ANGLE_DIV_I);
  localparam logic [RECIP_W-1:0] RECIP_TEMP  =
    RECIP_W'((longint'(1) << RECIP_SHIFT) / TEMP_DIV_I);

  localparam logic [DIV_W-1:0] TEMP_DIV = DIV_W'(TEMP_DIV_I);
  localparam logic signed [TMUL_W-1:0] TEMP_MUL = TMUL_W'(TEMP_MUL_I);
  localparam logic [TOFS_W-1:0] TEMP_OFS = TOFS_W'(TEMP_OFS_I);

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

  function automatic logic [MUL_W-1:0] kind_mul(input logic [1:0] kind);
    case (kind)
      KIND_ACCEL: kind_mul = MUL_W'(ACCEL_MUL_I);
      KIND_RATE:  kind_mul = MUL_W'(RATE_MUL_I);
      KIND_ANGLE: kind_mul = MUL_W'(ANGLE_MUL_I);
      default:    kind_mul = '0;
    endcase
  endfunction

  function automatic logic [DIV_W-1:0] kind_div(input logic [1:0] kind);
    case (kind)
      KIND_ACCEL: kind_div = DIV_W'(ACCEL_DIV_I);
      KIND_RATE:  kind_div = DIV_W'(RATE_DIV_I);
      KIND_ANGLE: kind_div = DIV_W'(ANGLE_DIV_I);
      default:    kind_div = DIV_W'(1);
    endcase
  endfunction

  function automatic logic [RECIP_W-1:0] kind_recip(input logic [1:0] kind);
    case (kind)
      KIND_ACCEL: kind_recip = RECIP_ACCEL;
      KIND_RATE:  kind_recip = RECIP_RATE;
      KIND_ANGLE: kind_recip = RECIP_ANGLE;
      default:    kind_recip = '0;
    endcase
  endfunction

  function automatic logic [7:0] kind_id(input logic [1:0] kind);
    case (kind)
      KIND_ACCEL: kind_id = ID_ACCEL;
      KIND_RATE:  kind_id = ID_RATE;
      KIND_ANGLE: kind_id = ID_ANGLE;
      default:    kind_id = 8'h00;
    endcase
  endfunction

endpackage

// File: design/irfe_axis_front.sv
// Axis lane front: sign/magnitude split, then magnitude times kind factor with fraction drop.
module irfe_axis_front #(
  parameter int VALUE_FRAC_BITS = irfe_pkg::VALUE_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  irfe_pkg::stage_en_t           en,
  input  logic signed [irfe_pkg::IN_W-1:0] value_i,
  input  logic [irfe_pkg::MUL_W-1:0]    mul_i,
  output logic                          neg_o,
  output logic [irfe_pkg::P_W-1:0]      p_o
);
  import irfe_pkg::*;

  logic            neg1_r;
  logic [IN_W-1:0] mag1_r;
  logic [IN_W-1:0] mag1_nxt;
  logic [P_W-1:0]  prod;
  logic [P_W-1:0]  p2_nxt;
  logic            neg2_r;
  logic [P_W-1:0]  p2_r;

  assign mag1_nxt = value_i[IN_W-1] ? (~value_i + IN_W'(1)) : value_i;
  assign prod     = P_W'(mag1_r) * P_W'(mul_i);
  assign p2_nxt   = prod >> VALUE_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      neg1_r <= value_i[IN_W-1];
      mag1_r <= mag1_nxt;
    end
    if (en.s2) begin
      neg2_r <= neg1_r;
      p2_r   <= p2_nxt;
    end
  end

  assign neg_o = neg2_r;
  assign p_o   = p2_r;
endmodule

// File: design/irfe_temp_front.sv
// Temperature lane front: t*1700 - 62101*2^F, then sign/magnitude with fraction drop.
module irfe_temp_front #(
  parameter int VALUE_FRAC_BITS = irfe_pkg::VALUE_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  irfe_pkg::stage_en_t              en,
  input  logic signed [irfe_pkg::IN_W-1:0] value_i,
  output logic                             neg_o,
  output logic [irfe_pkg::P_W-1:0]         p_o
);
  import irfe_pkg::*;

  localparam int OFS_W  = TOFS_W + VALUE_FRAC_BITS;
  localparam int TEMP_W = ((TP_W > OFS_W) ? TP_W : OFS_W) + 1;

  logic signed [TP_W-1:0]   tprod1_r;
  logic signed [TP_W-1:0]   tprod1_nxt;
  logic signed [TEMP_W-1:0] ofs;
  logic signed [TEMP_W-1:0] num;
  logic [TEMP_W-1:0]        mag;
  logic                     neg2_r;
  logic [P_W-1:0]           p2_r;

  assign tprod1_nxt = TP_W'(value_i) * TP_W'(TEMP_MUL);
  assign ofs        = $signed(TEMP_W'(TEMP_OFS) << VALUE_FRAC_BITS);
  assign num        = TEMP_W'(tprod1_r) - ofs;
  assign mag        = num[TEMP_W-1] ? (~num + TEMP_W'(1)) : num;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      tprod1_r <= tprod1_nxt;
    end
    if (en.s2) begin
      neg2_r <= num[TEMP_W-1];
      p2_r   <= P_W'(mag >> VALUE_FRAC_BITS);
    end
  end

  assign neg_o = neg2_r;
  assign p_o   = p2_r;
endmodule

// File: design/irfe_divsat.sv
// Constant division by reciprocal with one correction step, then int16 saturation.
module irfe_divsat (
  input  logic                          clk,
  input  irfe_pkg::stage_en_t           en,
  input  logic                          neg_i,
  input  logic [irfe_pkg::P_W-1:0]      p_i,
  input  logic [irfe_pkg::DIV_W-1:0]    div_i,
  input  logic [irfe_pkg::RECIP_W-1:0]  recip_i,
  output logic [irfe_pkg::Q_W-1:0]      word_o
);
  import irfe_pkg::*;

  localparam int PR_W = PLO_W + RECIP_W;
  localparam int QD_W = Q_W + DIV_W;

  logic [PLO_W-1:0] plo;
  logic [PLO_W-1:0] thresh;
  logic             sat3_nxt;
  logic [PR_W-1:0]  prq;
  logic             sat3_r;
  logic             neg3_r;
  logic [PLO_W-1:0] plo3_r;
  logic [Q_W-1:0]   qe3_r;
  logic [DIV_W-1:0] div3_r;
  logic [QD_W-1:0]  qd;
  logic [QD_W-1:0]  rem;
  logic [Q_W-1:0]   q;
  logic [Q_W-1:0]   word4_nxt;
  logic [Q_W-1:0]   word4_r;

  assign plo      = p_i[PLO_W-1:0];
  assign thresh   = {div_i, {(Q_W-1){1'b0}}};
  assign sat3_nxt = (p_i[P_W-1:PLO_W] != '0) || (plo >= thresh);
  assign prq      = PR_W'(plo) * PR_W'(recip_i);

  // estimate is exact or one low
  assign qd  = QD_W'(qe3_r) * QD_W'(div3_r);
  assign rem = QD_W'(plo3_r) - qd;
  assign q   = qe3_r + Q_W'(rem >= QD_W'(div3_r));

  always_comb begin
    if (sat3_r) begin
      word4_nxt = neg3_r ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
    end else if (neg3_r) begin
      word4_nxt = ~q + Q_W'(1);
    end else begin
      word4_nxt = q;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      sat3_r <= sat3_nxt;
      neg3_r <= neg_i;
      plo3_r <= plo;
      qe3_r  <= prq[RECIP_SHIFT +: Q_W];
      div3_r <= div_i;
    end
    if (en.s4) begin
      word4_r <= word4_nxt;
    end
  end

  assign word_o = word4_r;
endmodule

// File: design/irfe_frame_ser.sv
// Frame serializer: sync, id, four little-endian words and running checksum byte.
module irfe_frame_ser (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic [7:0]               id_i,
  input  logic [irfe_pkg::Q_W-1:0] x_i,
  input  logic [irfe_pkg::Q_W-1:0] y_i,
  input  logic [irfe_pkg::Q_W-1:0] z_i,
  input  logic [irfe_pkg::Q_W-1:0] t_i,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [7:0]               out_frame_byte,
  output logic                     out_last_byte
);
  import irfe_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

  logic             busy_r;
  logic             busy_nxt;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;
  logic [7:0]       sum_r;
  logic [7:0]       sum_nxt;
  logic [7:0]       id_r;
  logic [Q_W-1:0]   words_r [4];
  logic             last;
  logic             load;
  logic             take;

  assign last     = (idx_r == LAST_IDX);
  assign ready_o  = !busy_r || (out_ready && last);
  assign load     = valid_i && ready_o;
  assign take     = busy_r && out_ready;

  always_comb begin
    case (idx_r)
      4'd0:    out_frame_byte = SYNC_BYTE;
      4'd1:    out_frame_byte = id_r;
      4'd2:    out_frame_byte = words_r[0][7:0];
      4'd3:    out_frame_byte = words_r[0][15:8];
      4'd4:    out_frame_byte = words_r[1][7:0];
      4'd5:    out_frame_byte = words_r[1][15:8];
      4'd6:    out_frame_byte = words_r[2][7:0];
      4'd7:    out_frame_byte = words_r[2][15:8];
      4'd8:    out_frame_byte = words_r[3][7:0];
      4'd9:    out_frame_byte = words_r[3][15:8];
      default: out_frame_byte = sum_r;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    sum_nxt  = sum_r;
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      sum_nxt  = '0;
    end else if (take) begin
      if (last) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + IDX_W'(1);
        sum_nxt = sum_r + out_frame_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      sum_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      sum_r  <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      id_r       <= id_i;
      words_r[0] <= x_i;
      words_r[1] <= y_i;
      words_r[2] <= z_i;
      words_r[3] <= t_i;
    end
  end

  assign out_valid     = busy_r;
  assign out_last_byte = last;
endmodule

// File: design/imu_report_frame_encoder_core.sv
// IMU report frame encoder: scales one report per item and sends it as an 11-byte frame.
// Each accepted item (kind, x/y/z, temperature, signed fixed point with VALUE_FRAC_BITS
// fraction bits) runs through a four-stage scaling pipeline: sign split, multiply by the
// kind's factor, reciprocal divide, correction and int16 saturation. The frame then leaves
// one byte per cycle unless out_ready stalls it: 0x55, message id, x, y, z, temperature
// (little endian) and the low byte of the sum of the ten bytes before it, flagged by
// out_last_byte. The first byte shows once the item has passed the pipeline into the
// serializer; the output port sets the sustained rate, and up to four further items
// are held in the pipeline while a frame is sent. Kind 3 is consumed without a frame.
module imu_report_frame_encoder_core #(
  parameter int VALUE_FRAC_BITS = irfe_pkg::VALUE_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_cmd,
  input  logic signed [irfe_pkg::IN_W-1:0] in_x_value,
  input  logic signed [irfe_pkg::IN_W-1:0] in_y_value,
  input  logic signed [irfe_pkg::IN_W-1:0] in_z_value,
  input  logic signed [irfe_pkg::IN_W-1:0] in_temperature,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_frame_byte,
  output logic                             out_last_byte
);
  import irfe_pkg::*;

  stage_en_t        en;
  logic             v1_r, v2_r, v3_r, v4_r;
  logic             ser_ready;
  logic [1:0]       cmd1_r, cmd2_r, cmd3_r, cmd4_r;
  logic [MUL_W-1:0] mul2;
  logic [DIV_W-1:0] div3;
  logic [RECIP_W-1:0] recip3;
  logic             neg_x, neg_y, neg_z, neg_t;
  logic [P_W-1:0]   p_x, p_y, p_z, p_t;
  logic [Q_W-1:0]   w_x, w_y, w_z, w_t;

  assign en.s4    = !v4_r || ser_ready;
  assign en.s3    = !v3_r || en.s4;
  assign en.s2    = !v2_r || en.s3;
  assign en.s1    = !v1_r || en.s2;
  assign in_ready = en.s1;

  assign mul2   = kind_mul(cmd1_r);
  assign div3   = kind_div(cmd2_r);
  assign recip3 = kind_recip(cmd2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en.s1) v1_r <= in_valid && (in_cmd != KIND_NONE);
      if (en.s2) v2_r <= v1_r;
      if (en.s3) v3_r <= v2_r;
      if (en.s4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) cmd1_r <= in_cmd;
    if (en.s2) cmd2_r <= cmd1_r;
    if (en.s3) cmd3_r <= cmd2_r;
    if (en.s4) cmd4_r <= cmd3_r;
  end

  irfe_axis_front #(.VALUE_FRAC_BITS(VALUE_FRAC_BITS)) u_front_x (
    .clk(clk), .en(en), .value_i(in_x_value), .mul_i(mul2), .neg_o(neg_x), .p_o(p_x)
  );
  irfe_axis_front #(.VALUE_FRAC_BITS(VALUE_FRAC_BITS)) u_front_y (
    .clk(clk), .en(en), .value_i(in_y_value), .mul_i(mul2), .neg_o(neg_y), .p_o(p_y)
  );
  irfe_axis_front #(.VALUE_FRAC_BITS(VALUE_FRAC_BITS)) u_front_z (
    .clk(clk), .en(en), .value_i(in_z_value), .mul_i(mul2), .neg_o(neg_z), .p_o(p_z)
  );
  irfe_temp_front #(.VALUE_FRAC_BITS(VALUE_FRAC_BITS)) u_front_t (
    .clk(clk), .en(en), .value_i(in_temperature), .neg_o(neg_t), .p_o(p_t)
  );

  irfe_divsat u_div_x (
    .clk(clk), .en(en), .neg_i(neg_x), .p_i(p_x), .div_i(div3), .recip_i(recip3),
    .word_o(w_x)
  );
  irfe_divsat u_div_y (
    .clk(clk), .en(en), .neg_i(neg_y), .p_i(p_y), .div_i(div3), .recip_i(recip3),
    .word_o(w_y)
  );
  irfe_divsat u_div_z (
    .clk(clk), .en(en), .neg_i(neg_z), .p_i(p_z), .div_i(div3), .recip_i(recip3),
    .word_o(w_z)
  );
  irfe_divsat u_div_t (
    .clk(clk), .en(en), .neg_i(neg_t), .p_i(p_t), .div_i(TEMP_DIV), .recip_i(RECIP_TEMP),
    .word_o(w_t)
  );

  irfe_frame_ser u_ser (
    .clk           (clk),
    .rst_n         (rst_n),
    .valid_i       (v4_r),
    .ready_o       (ser_ready),
    .id_i          (kind_id(cmd4_r)),
    .x_i           (w_x),
    .y_i           (w_y),
    .z_i           (w_z),
    .t_i           (w_t),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_frame_byte(out_frame_byte),
    .out_last_byte (out_last_byte)
  );
endmodule

// File: design/irfe_checker.sv
// Port-level checker for the IMU report frame encoder, bound to the top level.
`include "imu_report_frame_encoder_core_macros.svh"

module irfe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_frame_byte,
  input logic       out_last_byte
);
  import irfe_pkg::*;

  `IRFE_ASSERT_NEXT_NR(a_reset_idle, clk, !rst_n, !out_valid, "output valid after reset")
  `IRFE_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_frame_byte) && $stable(out_last_byte), "stalled output item changed")
  `IRFE_ASSERT_NEXT(a_frame_gapless, clk, rst_n, out_valid && out_ready && !out_last_byte, out_valid, "gap inside a frame")
  `IRFE_ASSERT_NEXT(a_next_sync, clk, rst_n, out_valid && out_ready && out_last_byte, !out_valid || (out_frame_byte == SYNC_BYTE && !out_last_byte), "frame does not open with sync byte")
endmodule

bind imu_report_frame_encoder_core irfe_checker u_irfe_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_frame_byte(out_frame_byte),
  .out_last_byte (out_last_byte)
);

// File: tb/imu_report_frame_encoder_core_tb.sv
// Self-checking testbench for the IMU report frame encoder core.
`timescale 1ns / 1ps

module imu_report_frame_encoder_core_tb;
  import irfe_pkg::*;

  localparam int FRAC_BITS   = 16;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_WAIT  = 30;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } frame_beat_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_cmd = KIND_ACCEL;
  logic signed [31:0] in_x_value = '0;
  logic signed [31:0] in_y_value = '0;
  logic signed [31:0] in_z_value = '0;
  logic signed [31:0] in_temperature = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         out_frame_byte;
  logic               out_last_byte;

  frame_beat_t pending_bytes[$];
  frame_beat_t want_beat;
  bit          sender_idles = 1'b1;
  bit          receiver_idles = 1'b1;
  int          errors = 0;
  int          frames_sent = 0;
  int          unknown_sent = 0;
  int          bytes_checked = 0;
  int          cycle_count = 0;

  imu_report_frame_encoder_core #(
    .VALUE_FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_x_value    (in_x_value),
    .in_y_value    (in_y_value),
    .in_z_value    (in_z_value),
    .in_temperature(in_temperature),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_frame_byte(out_frame_byte),
    .out_last_byte (out_last_byte)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d bytes outstanding", $realtime, pending_bytes.size());
      $display("imu_report_frame_encoder_core_tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (receiver_idles && $urandom_range(99) < 16) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // int16 saturation of a sign and truncated magnitude, as a 16-bit pattern
  function automatic logic [15:0] sat_word(bit neg, longint unsigned mag);
    if (!neg) return (mag > 64'd32767) ? 16'h7fff : 16'(mag);
    if (mag >= 64'd32768) return 16'h8000;
    return 16'(64'd0 - mag);
  endfunction

  function automatic logic [15:0] scaled_axis(logic signed [31:0] v, longint unsigned mul,
                                              longint unsigned dv);
    longint          sv = v;
    bit              neg = (sv < 0);
    longint unsigned mag = neg ? longint'(-sv) : sv;
    return sat_word(neg, (mag * mul) / dv);
  endfunction

  function automatic logic [15:0] scaled_temp(logic signed [31:0] t);
    longint          one = longint'(1) << FRAC_BITS;
    longint          n = longint'(t) * 34000 - longint'(1242020) * one;
    bit              neg = (n < 0);
    longint unsigned mag = neg ? -n : n;
    return sat_word(neg, mag / longint'(100 * one));
  endfunction

  task automatic predict_frame(logic [1:0] cmd, logic signed [31:0] x, logic signed [31:0] y,
                               logic signed [31:0] z, logic signed [31:0] t);
    longint unsigned one = 64'd1 << FRAC_BITS;
    longint unsigned mul;
    longint unsigned dv;
    logic [7:0]      id;
    logic [15:0]     words[4];
    logic [7:0]      bytes[FRAME_LEN];
    logic [7:0]      sum;
    frame_beat_t     beat;
    case (cmd)
      KIND_ACCEL: begin
        id = ID_ACCEL;
        mul = 64'd3276700000;
        dv = 64'd16 * 64'd979135 * one;
      end
      KIND_RATE: begin
        id = ID_RATE;
        mul = 64'd32767;
        dv = 64'd2000 * one;
      end
      KIND_ANGLE: begin
        id = ID_ANGLE;
        mul = 64'd32767;
        dv = 64'd180 * one;
      end
      default: begin
        unknown_sent++;
        return;
      end
    endcase
    words[0] = scaled_axis(x, mul, dv);
    words[1] = scaled_axis(y, mul, dv);
    words[2] = scaled_axis(z, mul, dv);
    words[3] = scaled_temp(t);
    bytes[0] = SYNC_BYTE;
    bytes[1] = id;
    for (int i = 0; i < 4; i++) begin
      bytes[2 + 2 * i] = words[i][7:0];
      bytes[3 + 2 * i] = words[i][15:8];
    end
    sum = '0;
    for (int i = 0; i < FRAME_LEN - 1; i++) sum += bytes[i];
    bytes[FRAME_LEN - 1] = sum;
    for (int i = 0; i < FRAME_LEN; i++) begin
      beat.frame_byte = bytes[i];
      beat.last_byte = (i == FRAME_LEN - 1);
      pending_bytes.push_back(beat);
    end
    frames_sent++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      bytes_checked++;
      if (pending_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected byte: expected none, got %02h last %0b",
                 $realtime, out_frame_byte, out_last_byte);
      end else begin
        want_beat = pending_bytes.pop_front();
        if (out_frame_byte !== want_beat.frame_byte) begin
          errors++;
          $display("%0t: frame_byte mismatch: expected %02h, got %02h",
                   $realtime, want_beat.frame_byte, out_frame_byte);
        end
        if (out_last_byte !== want_beat.last_byte) begin
          errors++;
          $display("%0t: last_byte mismatch: expected %0b, got %0b",
                   $realtime, want_beat.last_byte, out_last_byte);
        end
      end
    end
  end

  // Drives one report item; an optional idle gap comes first, with junk payload.
  task automatic send_report(logic [1:0] cmd, logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z, logic signed [31:0] t);
    if (sender_idles && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      in_cmd <= 2'($urandom);
      in_x_value <= $urandom;
      in_y_value <= $urandom;
      in_z_value <= $urandom;
      in_temperature <= $urandom;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_x_value <= x;
    in_y_value <= y;
    in_z_value <= z;
    in_temperature <= t;
    do @(posedge clk); while (!in_ready);
    predict_frame(cmd, x, y, z, t);
  endtask

  task automatic hold_input_idle();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_value();
    logic signed [31:0] r = $urandom;
    if ($urandom_range(3) == 0) return r;
    return r >>> $urandom_range(8, 31);
  endfunction

  function automatic logic [1:0] rand_kind();
    if ($urandom_range(19) == 0) return KIND_NONE;
    return 2'($urandom_range(2));
  endfunction

  task automatic test_field_extremes();
    send_report(KIND_ACCEL, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    send_report(KIND_ACCEL, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_report(KIND_RATE, 32'sh7fffffff, 32'sh80000000, 32'sd0, 32'sd0);
    send_report(KIND_ANGLE, 32'sh80000000, 32'sh7fffffff, -32'sd1, -32'sd1);
    send_report(KIND_ACCEL, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    send_report(KIND_RATE, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    send_report(KIND_ANGLE, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
  endtask

  // truncation toward zero on small values and around the temperature offset
  task automatic test_truncation();
    send_report(KIND_ANGLE, -32'sd1, 32'sd1, -32'sd65536, 32'sd2393997);
    send_report(KIND_RATE, -32'sd65536, 32'sd65536, -32'sd4001, 32'sd2393998);
    send_report(KIND_ACCEL, 32'sd65536, -32'sd65536, -32'sd300, 32'sd2393804);
  endtask

  task automatic test_saturation_edges();
    send_report(KIND_ANGLE, 32'sd11796480, -32'sd11796480, 32'sd11862016, 32'sd8716288);
    send_report(KIND_ANGLE, -32'sd11862016, 32'sd11796479, -32'sd11796839, -32'sd3932160);
    send_report(KIND_RATE, 32'sd131072000, -32'sd131072000, -32'sd131076000, 32'sd8847360);
    send_report(KIND_ACCEL, 32'sd10267000, -32'sd10267000, 32'sd10266000, -32'sd6291456);
  endtask

  task automatic test_unknown_kind();
    send_report(KIND_RATE, 32'sd1000000, -32'sd1000000, 32'sd5, 32'sd1966080);
    send_report(KIND_NONE, 32'sh7fffffff, 32'sh80000000, 32'sh12345678, 32'sh0badf00d);
    send_report(KIND_NONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    send_report(KIND_ANGLE, -32'sd2000000, 32'sd2000000, 32'sd7, -32'sd1966080);
  endtask

  // sender stops until every byte in flight has been checked
  task automatic test_drain_pause();
    repeat (4) send_report(rand_kind(), rand_value(), rand_value(), rand_value(), rand_value());
    hold_input_idle();
    wait_drained();
    repeat (2) send_report(rand_kind(), rand_value(), rand_value(), rand_value(), rand_value());
  endtask

  task automatic run_random_reports(int count);
    int target = frames_sent + count;
    while (frames_sent < target) begin
      send_report(rand_kind(), rand_value(), rand_value(), rand_value(), rand_value());
    end
  endtask

  task automatic test_random_traffic();
    run_random_reports(150);
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    run_random_reports(100);
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    run_random_reports(150);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_field_extremes();
    test_truncation();
    test_saturation_edges();
    test_unknown_kind();
    test_drain_pause();
    test_random_traffic();
    hold_input_idle();
    wait_drained();
    $display("covered %0d frames of all three kinds, %0d bytes checked, %0d unknown-kind items",
             frames_sent, bytes_checked, unknown_sent);
    $display("field extremes, truncation, saturation edges and random stalls on both sides");
    if (errors == 0) begin
      $display("imu_report_frame_encoder_core_tb passed");
    end else begin
      $display("imu_report_frame_encoder_core_tb failed");
    end
    $finish;
  end

endmodule
